/* hdl/krlp_pkg.sv */
// krlp_pkg: shared types and constants of the key repeat and long press controller
// holds the item, result and configuration structs and the button bit positions
// no dependencies
package krlp_pkg;

  localparam int unsigned BTN_W     = 4;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned HOLD_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;
  localparam int unsigned IN_DAT_W  = 16;
  localparam int unsigned OUT_DAT_W = 8;

  localparam int unsigned BIT_LEFT  = 0;
  localparam int unsigned BIT_RIGHT = 1;
  localparam int unsigned BIT_OK    = 2;
  localparam int unsigned BIT_BACK  = 3;

  localparam logic [DELAY_W-1:0] DELAY_RST    = 8'd20;
  localparam logic [DELAY_W-1:0] INTERVAL_RST = 8'd5;
  localparam logic [HOLD_W-1:0]  HOLD_RST     = 10'd50;
  localparam logic               FONT_RST     = 1'b0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY    = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_HOLD     = 2'd2,
    REG_FONT     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_EVENT = 1'b1
  } act_t;

  typedef enum logic [1:0] {
    RKEY_NONE  = 2'd0,
    RKEY_LEFT  = 2'd1,
    RKEY_RIGHT = 2'd2,
    RKEY_BOTH  = 2'd3
  } rkey_t;

  typedef struct packed {
    act_t             action;
    logic [BTN_W-1:0] button_level;
    logic [BTN_W-1:0] pressed_mask;
    logic [BTN_W-1:0] changed_mask;
  } item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] repeat_initial_delay;
    logic [DELAY_W-1:0] repeat_interval;
    logic [HOLD_W-1:0]  hold_limit;
  } cfg_t;

  typedef struct packed {
    logic redraw;
    logic close_request;
    logic font_small;
    logic font_toggled;
    logic follow_latest;
    logic scroll_down;
    logic scroll_up;
  } res_t;

endpackage

/* hdl/krlp_in_stage.sv */
// krlp_in_stage: input register of the controller
// unpacks the incoming word and holds it until the step logic takes it; uses krlp_pkg
module krlp_in_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [krlp_pkg::IN_DAT_W-1:0]   in_tdata,
  input  logic                            in_tuser,
  input  logic                            take,
  output logic                            item_valid,
  output krlp_pkg::item_t                 item
);
  import krlp_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  // empty or draining this cycle
  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tready) begin
      valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.action       <= act_t'(in_tuser);
      item_r.button_level <= in_tdata[BTN_W-1:0];
      item_r.pressed_mask <= in_tdata[2*BTN_W-1:BTN_W];
      item_r.changed_mask <= in_tdata[3*BTN_W-1:2*BTN_W];
    end
  end

endmodule

/* hdl/krlp_step.sv */
// krlp_step: repeat, hold and font state with the per-item update logic
// computes one result from the held item and the current state; uses krlp_pkg
module krlp_step (
  input  logic             clk,
  input  logic             rst_n,
  input  krlp_pkg::cfg_t   cfg,
  input  logic             font_ld,
  input  logic             font_ld_val,
  input  logic             step_en,
  input  krlp_pkg::item_t  item,
  output krlp_pkg::res_t   res
);
  import krlp_pkg::*;

  rkey_t              rkey_r, rkey_nxt;
  logic [DELAY_W-1:0] cdown_r, cdown_nxt;
  logic               armed_r, armed_nxt;
  logic [HOLD_W-1:0]  hcnt_r, hcnt_nxt;
  logic               hdone_r, hdone_nxt;
  logic               font_r, font_nxt;

  logic [BTN_W-1:0]   lvl;
  logic [BTN_W-1:0]   prs;
  logic [BTN_W-1:0]   chg;
  logic [HOLD_W-1:0]  hcnt_inc;

  assign lvl = item.button_level;
  assign prs = item.pressed_mask;
  assign chg = item.changed_mask;

  always_comb begin
    rkey_nxt  = rkey_r;
    cdown_nxt = cdown_r;
    armed_nxt = armed_r;
    hcnt_nxt  = hcnt_r;
    hdone_nxt = hdone_r;
    font_nxt  = font_r;
    hcnt_inc  = hcnt_r;
    res       = '0;

    unique case (item.action)
      ACT_TICK: begin
        if (rkey_r != RKEY_NONE) begin
          if ((lvl[1:0] & rkey_r) == 2'b00) begin
            rkey_nxt  = RKEY_NONE;
            cdown_nxt = '0;
          end else if (cdown_r != '0) begin
            cdown_nxt = cdown_r - 1'b1;
          end else begin
            res.scroll_up   = (rkey_r == RKEY_LEFT);
            res.scroll_down = (rkey_r == RKEY_RIGHT);
            res.redraw      = 1'b1;
            cdown_nxt       = cfg.repeat_interval;
          end
        end
        if (armed_r && lvl[BIT_OK] && !hdone_r) begin
          // count saturates at the limit
          if (hcnt_r < cfg.hold_limit) begin
            hcnt_inc = hcnt_r + 1'b1;
          end
          hcnt_nxt = hcnt_inc;
          if (hcnt_inc >= cfg.hold_limit) begin
            hdone_nxt        = 1'b1;
            font_nxt         = !font_r;
            res.font_toggled = 1'b1;
            res.redraw       = 1'b1;
          end
        end
      end
      ACT_EVENT: begin
        if (prs[BIT_BACK]) begin
          res.close_request = 1'b1;
        end else begin
          if (prs[BIT_LEFT]) begin
            res.scroll_up = 1'b1;
            res.redraw    = 1'b1;
            rkey_nxt      = RKEY_LEFT;
            cdown_nxt     = cfg.repeat_initial_delay;
          end
          if (prs[BIT_RIGHT]) begin
            res.scroll_down = 1'b1;
            res.redraw      = 1'b1;
            rkey_nxt        = RKEY_RIGHT;
            cdown_nxt       = cfg.repeat_initial_delay;
          end
          if (prs[BIT_OK]) begin
            armed_nxt = 1'b1;
            hcnt_nxt  = '0;
            hdone_nxt = 1'b0;
          end
          // short press release, may follow an arm in the same event
          if (chg[BIT_OK] && !lvl[BIT_OK] && armed_nxt) begin
            if (!hdone_nxt) begin
              res.follow_latest = 1'b1;
              res.redraw        = 1'b1;
            end
            armed_nxt = 1'b0;
            hcnt_nxt  = '0;
            hdone_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    res.font_small = font_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rkey_r  <= RKEY_NONE;
      cdown_r <= '0;
      armed_r <= 1'b0;
      hcnt_r  <= '0;
      hdone_r <= 1'b0;
      font_r  <= FONT_RST;
    end else if (font_ld) begin
      font_r <= font_ld_val;
    end else if (step_en) begin
      rkey_r  <= rkey_nxt;
      cdown_r <= cdown_nxt;
      armed_r <= armed_nxt;
      hcnt_r  <= hcnt_nxt;
      hdone_r <= hdone_nxt;
      font_r  <= font_nxt;
    end
  end

endmodule

/* hdl/key_repeat_long_press_controller.sv */
// key_repeat_long_press_controller: top level with config registers and result register
// instantiates krlp_in_stage and krlp_step; uses krlp_pkg
//
//   port group | dir | payload
//   in_*       | in  | tdata: button_level, pressed_mask, changed_mask; tuser: action
//   out_*      | out | tdata: scroll_up .. redraw, one bit each
//   cfg_*      | in  | register index and write data, no read-back
//
// one item per cycle unless the output stalls; the result register follows the input register
// the input register and the result register each hold one word, so input is
// taken while a finished result waits; a stalled output backs up after two words
// rst_n clears all control state and loads the register defaults
module key_repeat_long_press_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [krlp_pkg::IN_DAT_W-1:0]    in_tdata,   // button_level, pressed_mask, changed_mask
  input  logic                             in_tuser,   // action
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [krlp_pkg::OUT_DAT_W-1:0]   out_tdata,  // scroll_up, scroll_down, follow_latest,
                                                       // font_toggled, font_small, close_request,
                                                       // redraw
  input  logic                             cfg_wr_en,
  input  logic [krlp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [krlp_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
  import krlp_pkg::*;

  cfg_t  cfg_r;
  logic  font_ld;
  logic  item_valid;
  item_t item;
  logic  take;
  res_t  res;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;

  assign take    = item_valid && (!out_valid_r || out_tready);
  assign font_ld = cfg_wr_en && (cfg_reg_t'(cfg_index) == REG_FONT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.repeat_initial_delay <= DELAY_RST;
      cfg_r.repeat_interval      <= INTERVAL_RST;
      cfg_r.hold_limit           <= HOLD_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DELAY:    cfg_r.repeat_initial_delay <= cfg_wdata[DELAY_W-1:0];
        REG_INTERVAL: cfg_r.repeat_interval      <= cfg_wdata[DELAY_W-1:0];
        REG_HOLD:     cfg_r.hold_limit           <= cfg_wdata[HOLD_W-1:0];
        REG_FONT: begin
        end
        default: begin
        end
      endcase
    end
  end

  krlp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  krlp_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .font_ld     (font_ld),
    .font_ld_val (cfg_wdata[0]),
    .step_en     (take),
    .item        (item),
    .res         (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_res_r};

endmodule

/* bench/krlp_action_checker.sv */
`timescale 1ns / 1ps
// krlp_action_checker: watches the input, result and config ports of the key repeat controller
// predicts the action word of every accepted input word and compares it with the result stream
// depends on krlp_pkg
module krlp_action_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [krlp_pkg::IN_DAT_W-1:0]  in_tdata,   // button_level, pressed_mask, changed_mask
  input  logic                           in_tuser,   // action
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [krlp_pkg::OUT_DAT_W-1:0] out_tdata,  // scroll_up, scroll_down, follow_latest,
                                                     // font_toggled, font_small, close_request,
                                                     // redraw
  input  logic                           cfg_wr_en,
  input  logic [krlp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [krlp_pkg::CFG_DAT_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             outstanding
);
  import krlp_pkg::*;

  logic [DELAY_W-1:0] delay_r;
  logic [DELAY_W-1:0] interval_r;
  logic [HOLD_W-1:0]  hold_r;

  rkey_t              rep_key;
  logic [DELAY_W-1:0] rep_count;
  logic               ok_armed;
  logic [HOLD_W-1:0]  ok_count;
  logic               ok_done;
  logic               small_font;

  res_t  pending_actions[$];
  item_t seen_word;
  res_t  got_word;
  res_t  want_word;

  function automatic res_t next_key_actions(input item_t it);
    res_t r;
    r = '0;
    if (it.action == ACT_TICK) begin
      if (rep_key != RKEY_NONE) begin
        if ((it.button_level[1:0] & rep_key) == 2'b00) begin
          rep_key   = RKEY_NONE;
          rep_count = '0;
        end else if (rep_count != '0) begin
          rep_count = rep_count - 8'd1;
        end else begin
          if (rep_key == RKEY_LEFT) r.scroll_up = 1'b1;
          else if (rep_key == RKEY_RIGHT) r.scroll_down = 1'b1;
          r.redraw  = 1'b1;
          rep_count = interval_r;
        end
      end
      if (ok_armed && it.button_level[BIT_OK] && !ok_done) begin
        if (ok_count < hold_r) ok_count = ok_count + 10'd1;
        if (ok_count >= hold_r) begin
          ok_done        = 1'b1;
          small_font     = ~small_font;
          r.font_toggled = 1'b1;
          r.redraw       = 1'b1;
        end
      end
    end else if (it.pressed_mask[BIT_BACK]) begin
      r.close_request = 1'b1;
    end else begin
      if (it.pressed_mask[BIT_LEFT]) begin
        r.scroll_up = 1'b1;
        r.redraw    = 1'b1;
        rep_key     = RKEY_LEFT;
        rep_count   = delay_r;
      end
      if (it.pressed_mask[BIT_RIGHT]) begin
        r.scroll_down = 1'b1;
        r.redraw      = 1'b1;
        rep_key       = RKEY_RIGHT;
        rep_count     = delay_r;
      end
      if (it.pressed_mask[BIT_OK]) begin
        ok_armed = 1'b1;
        ok_count = '0;
        ok_done  = 1'b0;
      end
      if (it.changed_mask[BIT_OK] && !it.button_level[BIT_OK] && ok_armed) begin
        if (!ok_done) begin
          r.follow_latest = 1'b1;
          r.redraw        = 1'b1;
        end
        ok_armed = 1'b0;
        ok_count = '0;
        ok_done  = 1'b0;
      end
    end
    r.font_small = small_font;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      delay_r    = DELAY_RST;
      interval_r = INTERVAL_RST;
      hold_r     = HOLD_RST;
      rep_key    = RKEY_NONE;
      rep_count  = '0;
      ok_armed   = 1'b0;
      ok_count   = '0;
      ok_done    = 1'b0;
      small_font = FONT_RST;
      mismatches = 0;
      pending_actions.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got_word = res_t'(out_tdata[6:0]);
        if (pending_actions.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result word %b with nothing pending", $time, got_word);
        end else begin
          want_word = pending_actions.pop_front();
          // bit order: redraw close small toggled follow down up
          if (got_word !== want_word) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: result mismatch, expected %b got %b", $time, want_word, got_word);
          end
        end
      end
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_DELAY:    delay_r    = cfg_wdata[DELAY_W-1:0];
          REG_INTERVAL: interval_r = cfg_wdata[DELAY_W-1:0];
          REG_HOLD:     hold_r     = cfg_wdata[HOLD_W-1:0];
          REG_FONT:     small_font = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        seen_word.action       = act_t'(in_tuser);
        seen_word.button_level = in_tdata[3:0];
        seen_word.pressed_mask = in_tdata[7:4];
        seen_word.changed_mask = in_tdata[11:8];
        pending_actions.push_back(next_key_actions(seen_word));
      end
    end
    outstanding = pending_actions.size();
  end

endmodule

/* bench/key_repeat_long_press_controller_test.sv */
`timescale 1ns / 1ps
// key_repeat_long_press_controller_test: gesture stimulus, config phases and verdict
// drives directed and random button words with random gaps and stalls
// depends on krlp_pkg, key_repeat_long_press_controller and krlp_action_checker
module key_repeat_long_press_controller_test;
  import krlp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [IN_DAT_W-1:0]  in_tdata   = '0;   // [3:0] button_level, [7:4] pressed_mask, [11:8] changed_mask
  logic                 in_tuser   = 1'b0; // action
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DAT_W-1:0] out_tdata;         // scroll_up .. redraw, one bit each
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata  = '0;

  int    mismatches;
  int    outstanding;
  int    cycle_count  = 0;
  bit    gaps_on      = 1'b1;
  int    cur_delay    = DELAY_RST;
  int    cur_interval = INTERVAL_RST;
  int    cur_hold     = HOLD_RST;
  int    phase_words;
  item_t gesture_q[$];

  key_repeat_long_press_controller uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  krlp_action_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= !(gaps_on && $urandom_range(99) < 6);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  task automatic push_word(input act_t a, input logic [3:0] lvl, input logic [3:0] prs,
                           input logic [3:0] chg);
    item_t it;
    it.action       = a;
    it.button_level = lvl;
    it.pressed_mask = prs;
    it.changed_mask = chg;
    gesture_q.push_back(it);
  endtask

  task automatic push_tick(input logic [3:0] lvl);
    push_word(ACT_TICK, lvl, 4'($urandom_range(15)), 4'($urandom_range(15)));
  endtask

  task automatic send_word(input item_t it);
    while (gaps_on && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.action;
    in_tdata  <= {4'b0000, it.changed_mask, it.pressed_mask, it.button_level};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic play_queue();
    while (gesture_q.size() > 0) begin
      send_word(gesture_q.pop_front());
      phase_words++;
    end
  endtask

  task automatic plan_gesture();
    int         n;
    int         lim;
    int         cut;
    logic [3:0] held;
    logic [3:0] extra;
    case ($urandom_range(9))
      0, 1, 2: begin
        // left/right press, held ticks, release
        held = {2'b00, 2'($urandom_range(1, 3))};
        if ($urandom_range(3) == 0) held[BIT_OK] = 1'b1;
        push_word(ACT_EVENT, held, held, held);
        lim = cur_delay + 3 * cur_interval + 4;
        if (lim > 45) lim = 45;
        n = $urandom_range(lim);
        for (int i = 0; i < n; i++) begin
          extra = ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'b0000;
          if ($urandom_range(29) == 0) push_tick(extra);
          else push_tick(held | extra);
        end
        push_word(ACT_EVENT, 4'b0000, 4'b0000, held);
      end
      3, 4: begin
        // ok press, hold, release
        push_word(ACT_EVENT, 4'b0100, 4'b0100, 4'b0100);
        lim = cur_hold + 4;
        if (lim > 60) lim = 60;
        n   = $urandom_range(lim);
        cut = ($urandom_range(3) == 0) ? $urandom_range(n) : -1;
        for (int i = 0; i < n; i++) begin
          if (i == cut) push_word(ACT_EVENT, 4'b0101, 4'b0001, 4'b0001);
          extra = ($urandom_range(5) == 0) ? 4'($urandom_range(15)) : 4'b0000;
          if ($urandom_range(39) == 0) push_tick(extra & 4'b1011);
          else push_tick(4'b0100 | extra);
        end
        push_word(ACT_EVENT, {2'b00, 2'($urandom_range(3))}, 4'b0000, 4'b0100);
      end
      5: begin
        push_word(ACT_EVENT, 4'($urandom_range(15)), 4'($urandom_range(15)) | 4'b1000,
                  4'($urandom_range(15)));
      end
      6: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
          push_word(act_t'(1'($urandom_range(1))), 4'($urandom_range(15)),
                    4'($urandom_range(15)), 4'($urandom_range(15)));
      end
      7: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_tick(4'($urandom_range(15)));
      end
      8: begin
        // ok pressed and released within one word
        extra = {2'b00, 2'($urandom_range(3))};
        push_word(ACT_EVENT, extra, 4'b0100 | extra, 4'b0100 | extra);
      end
      default: begin
        // release with no matching press
        push_word(ACT_EVENT, 4'($urandom_range(15)) & 4'b0011, 4'b0000,
                  4'($urandom_range(15)));
      end
    endcase
  endtask

  task automatic run_phase(input int target);
    phase_words = 0;
    while (phase_words < target) begin
      plan_gesture();
      play_queue();
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] dly, input logic [7:0] ivl,
                            input logic [9:0] hld, input logic fnt);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_DELAY;
    cfg_wdata <= {2'b00, dly};
    @(posedge clk);
    cfg_index <= REG_INTERVAL;
    cfg_wdata <= {2'b00, ivl};
    @(posedge clk);
    cfg_index <= REG_HOLD;
    cfg_wdata <= hld;
    @(posedge clk);
    cfg_index <= REG_FONT;
    cfg_wdata <= {9'b0, fnt};
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    cur_delay    = dly;
    cur_interval = ivl;
    cur_hold     = hld;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset defaults
    push_word(ACT_TICK,  4'b0000, 4'b0000, 4'b0000);
    push_word(ACT_EVENT, 4'b1111, 4'b1111, 4'b1111);
    push_word(ACT_TICK,  4'b1111, 4'b1111, 4'b1111);
    push_word(ACT_EVENT, 4'b0001, 4'b0001, 4'b0001);
    push_word(ACT_TICK,  4'b0001, 4'b0000, 4'b0000);
    push_word(ACT_EVENT, 4'b0011, 4'b0010, 4'b0010);
    push_word(ACT_TICK,  4'b0001, 4'b0000, 4'b0000);
    push_word(ACT_EVENT, 4'b0011, 4'b0011, 4'b0011);
    push_word(ACT_TICK,  4'b0011, 4'b0000, 4'b0000);
    push_word(ACT_EVENT, 4'b0000, 4'b0000, 4'b0011);
    push_word(ACT_EVENT, 4'b0000, 4'b0100, 4'b0100);
    push_word(ACT_EVENT, 4'b0100, 4'b0100, 4'b0100);
    push_word(ACT_TICK,  4'b0100, 4'b0000, 4'b0000);
    push_word(ACT_TICK,  4'b1100, 4'b1000, 4'b1000);
    push_word(ACT_EVENT, 4'b0000, 4'b0000, 4'b0100);
    push_word(ACT_EVENT, 4'b0000, 4'b0000, 4'b0100);
    push_word(ACT_EVENT, 4'b1100, 4'b1100, 4'b1100);
    push_word(ACT_TICK,  4'b1000, 4'b0000, 4'b0000);
    push_word(ACT_EVENT, 4'b1111, 4'b0000, 4'b1111);
    phase_words = 0;
    play_queue();

    run_phase(230);
    wait_idle();

    set_config(8'd0, 8'd0, 10'd0, 1'b1);
    run_phase(200);
    wait_idle();

    set_config(8'd255, 8'd255, 10'd1023, 1'b0);
    run_phase(120);
    wait_idle();

    gaps_on = 1'b0;
    set_config(8'd3, 8'd2, 10'd6, 1'b1);
    run_phase(250);
    wait_idle();
    gaps_on = 1'b1;

    repeat (3) begin
      set_config(8'($urandom_range(8)), 8'($urandom_range(5)), 10'($urandom_range(15)),
                 1'($urandom_range(1)));
      run_phase(180);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
